/* src/sipl_pkg.sv */
// Shared types and constants for the sorted index page lookup.
// Used by the top level and the checker; depends on nothing.
package sipl_pkg;

  localparam int KEY_FIELD_W = 64;
  localparam int PAGE_W      = 10;
  localparam int COUNT_W     = 11;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_RANGE  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  typedef struct packed {
    logic [1:0]             mode;
    logic [PAGE_W-1:0]      entry_index;
    logic [KEY_FIELD_W-1:0] key;
    logic [KEY_FIELD_W-1:0] upper_key;
    logic                   use_lower;
    logic                   use_upper;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [PAGE_W-1:0] first_page;
    logic [PAGE_W-1:0] last_page;
  } out_item_t;

endpackage

/* src/sipl_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module sipl_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/sorted_index_page_lookup.sv */
// Top level of the sorted index page lookup: sequencer, search registers, key table.
// Depends on sipl_pkg and sipl_ram.
//
// A load leaves busy low, and the acknowledge strobes on out_valid in the next cycle. A
// lookup runs one lower-bound binary search, one key-table probe per clock through a
// single KEY_WIDTH-bit compare unit, for at most ceil(log2(n+1)) probes. A range query
// runs up to two such searches back to back. The probe rate is set by the one read port
// of the key table. busy is high while a search runs; a result on out_data is marked by
// out_valid for one cycle only, and the receiver cannot stall it. entry_count above
// TABLE_DEPTH acts as TABLE_DEPTH; keys use their low KEY_WIDTH bits.
module sorted_index_page_lookup #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  sipl_pkg::in_item_t          in_data,
  output logic                        out_valid,
  output sipl_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [sipl_pkg::COUNT_W-1:0] cfg_wdata
);

  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int PW     = sipl_pkg::PAGE_W;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_PROBE} state_t;

  state_t                       state_r, state_nxt;
  logic [sipl_pkg::COUNT_W-1:0] cfg_count_r;
  logic [CNT_W-1:0]             lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt, n_r, n_nxt;
  logic [KEY_WIDTH-1:0]         sk_r, sk_nxt, uk_r, uk_nxt;
  logic                         range_r, range_nxt, upper_r, upper_nxt;
  logic                         use_upper_r, use_upper_nxt;
  logic [PW-1:0]                first_r, first_nxt;
  logic                         out_valid_r, out_valid_nxt;
  sipl_pkg::out_item_t          out_r, out_nxt;

  logic [31:0]          cnt_ext;
  logic [CNT_W-1:0]     n_cfg;
  logic [CNT_W:0]       sum_i, sum_c;
  logic [CNT_W-1:0]     mid_i, mid_c, lo_c, hi_c;
  logic                 key_less, found_c;
  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [KEY_WIDTH-1:0] ram_rdata;
  logic                 accept, idx_in_range;

  assign accept       = start && (state_r == ST_IDLE);
  assign cnt_ext      = 32'(cfg_count_r);
  assign n_cfg        = CNT_W'((cnt_ext > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : cnt_ext);
  assign idx_in_range = 32'(in_data.entry_index) < 32'(TABLE_DEPTH);

  assign sum_i    = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_i    = CNT_W'(sum_i >> 1);
  assign key_less = ram_rdata < sk_r;
  assign lo_c     = key_less ? (mid_r + CNT_W'(1)) : lo_r;
  assign hi_c     = key_less ? hi_r : mid_r;
  assign sum_c    = {1'b0, lo_c} + {1'b0, hi_c};
  assign mid_c    = CNT_W'(sum_c >> 1);
  assign found_c  = lo_c < n_r;

  sipl_ram #(
    .WIDTH  (KEY_WIDTH),
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_key_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(in_data.entry_index)),
    .wdata (KEY_WIDTH'(in_data.key)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    n_nxt         = n_r;
    sk_nxt        = sk_r;
    uk_nxt        = uk_r;
    range_nxt     = range_r;
    upper_nxt     = upper_r;
    use_upper_nxt = use_upper_r;
    first_nxt     = first_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = ADDR_W'(mid_i);

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          n_nxt         = n_cfg;
          lo_nxt        = '0;
          hi_nxt        = n_cfg;
          uk_nxt        = KEY_WIDTH'(in_data.upper_key);
          use_upper_nxt = in_data.use_upper;
          first_nxt     = '0;
          out_nxt       = '{sipl_pkg::STATUS_NOT_FOUND, '0, '0};
          unique case (in_data.mode) inside
            sipl_pkg::MODE_LOAD: begin
              ram_we        = idx_in_range;
              out_valid_nxt = 1'b1;
              out_nxt       = '{sipl_pkg::STATUS_OK, '0, '0};
            end
            sipl_pkg::MODE_LOOKUP, sipl_pkg::MODE_RANGE: begin
              range_nxt = (in_data.mode == sipl_pkg::MODE_RANGE);
              if (n_cfg == '0) begin
                out_valid_nxt = 1'b1;
              end else if (in_data.mode == sipl_pkg::MODE_LOOKUP || in_data.use_lower) begin
                sk_nxt    = KEY_WIDTH'(in_data.key);
                upper_nxt = 1'b0;
                state_nxt = ST_ISSUE;
              end else if (in_data.use_upper) begin
                sk_nxt    = KEY_WIDTH'(in_data.upper_key);
                upper_nxt = 1'b1;
                state_nxt = ST_ISSUE;
              end else begin
                out_valid_nxt = 1'b1;
                out_nxt       = '{sipl_pkg::STATUS_OK, '0, PW'(n_cfg - CNT_W'(1))};
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_ISSUE: begin
        ram_re    = 1'b1;
        ram_raddr = ADDR_W'(mid_i);
        mid_nxt   = mid_i;
        state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        lo_nxt = lo_c;
        hi_nxt = hi_c;
        if (lo_c < hi_c) begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(mid_c);
          mid_nxt   = mid_c;
        end else if (!upper_r) begin
          if (!found_c) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{sipl_pkg::STATUS_NOT_FOUND, '0, '0};
            state_nxt     = ST_IDLE;
          end else if (!range_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{sipl_pkg::STATUS_OK, PW'(lo_c), PW'(lo_c)};
            state_nxt     = ST_IDLE;
          end else if (use_upper_r) begin
            first_nxt = PW'(lo_c);
            sk_nxt    = uk_r;
            upper_nxt = 1'b1;
            lo_nxt    = '0;
            hi_nxt    = n_r;
            state_nxt = ST_ISSUE;
          end else begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{sipl_pkg::STATUS_OK, PW'(lo_c), PW'(n_r - CNT_W'(1))};
            state_nxt     = ST_IDLE;
          end
        end else begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{sipl_pkg::STATUS_OK, first_r,
                            found_c ? PW'(lo_c) : PW'(n_r - CNT_W'(1))};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cfg_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_count_r <= cfg_wdata;
      end
    end
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    n_r         <= n_nxt;
    sk_r        <= sk_nxt;
    uk_r        <= uk_nxt;
    range_r     <= range_nxt;
    upper_r     <= upper_nxt;
    use_upper_r <= use_upper_nxt;
    first_r     <= first_nxt;
    out_r       <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* src/sipl_checker.sv */
// Port-level checks for the sorted index page lookup, bound to the top level.
// Depends on sipl_pkg and sorted_index_page_lookup.
module sipl_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input sipl_pkg::in_item_t           in_data,
  input logic                         out_valid,
  input sipl_pkg::out_item_t          out_data
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block not quiet after reset");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted transfer neither searched nor answered");

  a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.mode == sipl_pkg::MODE_LOAD
    |=> out_valid && !busy && out_data.status == sipl_pkg::STATUS_OK)
    else $error("load not acknowledged in the next cycle");

  a_search_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("search ended without a result");

  a_miss_pages: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == sipl_pkg::STATUS_NOT_FOUND
    |-> out_data.first_page == '0 && out_data.last_page == '0)
    else $error("not-found result carries pages");

endmodule

bind sorted_index_page_lookup sipl_checker u_sipl_checker (.*);
